// ----- hw/rtl/ipf_pkg.sv -----
package ipf_pkg;

    localparam int PIX_W    = 8;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_BG     = 2'd2,
        REG_FG     = 2'd3
    } cfg_reg_t;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 12'd480;
    localparam logic [PIX_W-1:0]    RST_BG     = 8'd0;
    localparam logic [PIX_W-1:0]    RST_FG     = 8'd255;

endpackage

// ----- hw/rtl/ipf_if.sv -----
interface ipf_in_if;
    logic                      valid;
    logic                      ready;
    logic [ipf_pkg::PIX_W-1:0] pixel_in;
    logic                      is_padding;

    modport source (output valid, output pixel_in, output is_padding, input ready);
    modport sink   (input valid, input pixel_in, input is_padding, output ready);
endinterface

interface ipf_out_if;
    logic                      valid;
    logic                      ready;
    logic [ipf_pkg::PIX_W-1:0] pixel_out;
    logic                      row_end;
    logic                      frame_end;

    modport source (output valid, output pixel_out, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                    output ready);
endinterface

// ----- hw/rtl/isolated_pixel_filter_3x3.sv -----
// Isolated background pixel filter over a 3x3 window, one pixel per clock in raster
// order when not stalled. A background centre whose left, right, up, down, up-left
// and down-right neighbours are all non-background (or outside the image) is replaced
// by the foreground value; every other pixel passes unchanged. Each result leaves the
// block W+1 accepted items after its own input pixel, so W+1 padding items flush the
// last row; padding sent while frame pixels are still expected is dropped.
// Throughput, unless stalled, is one item per cycle, set by the single read and write
// port of each of the two line stores (MAX_WIDTH x 8 bits); a result register and one
// stage in front of it let a new item enter while a finished result waits. Any
// register write holds off input until a bit-serial divider rebuilds the output row
// and column from the linear output position.
module isolated_pixel_filter_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ipf_in_if.sink                      stream_in,
    ipf_out_if.source                   stream_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ipf_pkg::ADDR_W-1:0]  paddr,
    input  logic [ipf_pkg::DATA_W-1:0]  pwdata,
    output logic [ipf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int PW    = ipf_pkg::PIX_W;
    localparam int HW    = ipf_pkg::HEIGHT_W;
    localparam int HMAX  = (1 << HW) - 1;
    localparam int WCAP  = (1 << ipf_pkg::WIDTH_W) - 1;
    localparam int WMAX  = (MAX_WIDTH < WCAP) ? MAX_WIDTH : WCAP;
    localparam int WW    = $clog2(WMAX + 1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CMPW  = ((AW > WW) ? AW : WW) + 1;
    localparam int PB    = $clog2(WMAX * HMAX + 1);
    localparam int PRODW = WW + HW;
    localparam int RW    = HW + 2;
    localparam int DCW   = $clog2(PB + 1);

    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
        logic last;
    } border_t;

    logic [ipf_pkg::WIDTH_W-1:0] width_reg;
    logic [HW-1:0]               height_reg;
    logic [PW-1:0]               bg_reg;
    logic [PW-1:0]               fg_reg;
    logic                        wr_d_reg;

    logic [WW-1:0]               eff_w;
    logic [HW-1:0]               eff_h;
    logic [PRODW-1:0]            wh_full;
    logic [PB-1:0]               wh_reg;

    logic [AW-1:0]               col_reg;
    logic [RW-1:0]               row_reg;
    logic [PB-1:0]               out_pos_reg;
    logic [PB-1:0]               out_row_reg;
    logic [AW-1:0]               out_col_reg;

    logic                        div_busy_reg;
    logic [DCW-1:0]              div_cnt_reg;
    logic [PB-1:0]               div_q_reg;
    logic [WW-1:0]               div_rem_reg;
    logic [WW:0]                 div_trial;
    logic [WW:0]                 div_sub;
    logic                        div_ge;
    logic [WW-1:0]               div_rem_step;
    logic [PB-1:0]               div_q_step;

    logic [PW-1:0]               up_mem  [MAX_WIDTH];
    logic [PW-1:0]               mid_mem [MAX_WIDTH];
    logic                        upw_valid_reg;
    logic [AW-1:0]               upw_addr_reg;

    logic                        s1_valid_reg;
    logic [PW-1:0]               s1_pix_reg;
    logic                        s1_emit_reg;
    border_t                     s1_bd_reg;
    logic [PW-1:0]               top_q_reg;
    logic [PW-1:0]               mid_q_reg;

    logic [PW-1:0]               win_t1_reg;
    logic [PW-1:0]               win_t2_reg;
    logic [PW-1:0]               win_m1_reg;
    logic [PW-1:0]               win_m2_reg;
    logic [PW-1:0]               win_b2_reg;

    logic                        out_valid_reg;
    logic [PW-1:0]               pixel_out_reg;
    logic                        row_end_reg;
    logic                        frame_end_reg;

    logic                        cfg_we;
    logic                        busy;
    logic                        in_fire;
    logic                        in_frame;
    logic                        drop;
    logic                        acc_go;
    logic [PW-1:0]               pix_s0;
    logic [AW-1:0]               col_s0;
    logic                        emit_s0;
    logic                        col_wrap;
    logic                        fwd;
    border_t                     bd_s0;
    logic                        out_load;
    logic                        s1_move;
    logic                        nb_any;
    logic [PW-1:0]               result;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        unique case (ipf_pkg::cfg_reg_t'(paddr[3:2]))
            ipf_pkg::REG_WIDTH:  prdata = ipf_pkg::DATA_W'(width_reg);
            ipf_pkg::REG_HEIGHT: prdata = ipf_pkg::DATA_W'(height_reg);
            ipf_pkg::REG_BG:     prdata = ipf_pkg::DATA_W'(bg_reg);
            ipf_pkg::REG_FG:     prdata = ipf_pkg::DATA_W'(fg_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ipf_pkg::RST_WIDTH;
            height_reg <= ipf_pkg::RST_HEIGHT;
            bg_reg     <= ipf_pkg::RST_BG;
            fg_reg     <= ipf_pkg::RST_FG;
            wr_d_reg   <= 1'b0;
        end
        else
        begin
            wr_d_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (ipf_pkg::cfg_reg_t'(paddr[3:2]))
                    ipf_pkg::REG_WIDTH:  width_reg  <= pwdata[ipf_pkg::WIDTH_W-1:0];
                    ipf_pkg::REG_HEIGHT: height_reg <= pwdata[HW-1:0];
                    ipf_pkg::REG_BG:     bg_reg     <= pwdata[PW-1:0];
                    ipf_pkg::REG_FG:     fg_reg     <= pwdata[PW-1:0];
                endcase
            end
        end
    end

    // effective frame size
    always_comb
    begin
        if (width_reg == '0)
            eff_w = WW'(1);
        else if (int'(width_reg) > WMAX)
            eff_w = WW'(WMAX);
        else
            eff_w = WW'(width_reg);
        eff_h = (height_reg == '0) ? HW'(1) : height_reg;
    end

    assign wh_full = PRODW'(eff_w) * PRODW'(eff_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wh_reg <= PB'(int'(ipf_pkg::RST_WIDTH) * int'(ipf_pkg::RST_HEIGHT));
        else
            wh_reg <= wh_full[PB-1:0];
    end

    // output row and column from linear position, one quotient bit per cycle
    assign div_trial    = {div_rem_reg, div_q_reg[PB-1]};
    assign div_sub      = div_trial - {1'b0, eff_w};
    assign div_ge       = div_trial >= {1'b0, eff_w};
    assign div_rem_step = div_ge ? div_sub[WW-1:0] : div_trial[WW-1:0];
    assign div_q_step   = {div_q_reg[PB-2:0], div_ge};

    assign busy = wr_d_reg || div_busy_reg;

    // input stage
    assign in_fire  = stream_in.valid && stream_in.ready;
    assign in_frame = row_reg < RW'(eff_h);
    assign drop     = in_frame && stream_in.is_padding;
    assign acc_go   = in_fire && !drop;
    assign pix_s0   = in_frame ? stream_in.pixel_in : '0;
    assign col_s0   = (CMPW'(col_reg) >= CMPW'(eff_w)) ? '0 : col_reg;
    assign emit_s0  = (row_reg >= RW'(2)) || (row_reg == RW'(1) && col_s0 != '0);
    assign col_wrap = (CMPW'(col_s0) + CMPW'(1)) >= CMPW'(eff_w);
    assign fwd      = upw_valid_reg && (upw_addr_reg == col_s0);

    assign bd_s0.up    = out_row_reg != '0;
    assign bd_s0.down  = ((PB + 1)'(out_row_reg) + (PB + 1)'(1)) < (PB + 1)'(eff_h);
    assign bd_s0.left  = out_col_reg != '0;
    assign bd_s0.right = (CMPW'(out_col_reg) + CMPW'(1)) < CMPW'(eff_w);
    assign bd_s0.last  = ((PB + 1)'(out_pos_reg) + (PB + 1)'(1)) >= (PB + 1)'(wh_reg);

    assign out_load = !out_valid_reg || stream_out.ready;
    assign s1_move  = s1_valid_reg && (!s1_emit_reg || out_load);

    assign stream_in.ready = !busy && (!s1_valid_reg || s1_move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            out_pos_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (wr_d_reg)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= DCW'(PB);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
            if (div_cnt_reg == DCW'(1))
            begin
                div_busy_reg <= 1'b0;
                out_row_reg  <= div_q_step;
                out_col_reg  <= AW'(div_rem_step);
            end
        end
        else if (acc_go)
        begin
            if (emit_s0 && bd_s0.last)
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                out_pos_reg <= '0;
                out_row_reg <= '0;
                out_col_reg <= '0;
            end
            else
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_s0 + AW'(1);
                end
                if (emit_s0)
                begin
                    out_pos_reg <= out_pos_reg + PB'(1);
                    if (bd_s0.right)
                    begin
                        out_col_reg <= out_col_reg + AW'(1);
                    end
                    else
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + PB'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_d_reg)
        begin
            div_q_reg   <= out_pos_reg;
            div_rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            div_q_reg   <= div_q_step;
            div_rem_reg <= div_rem_step;
        end
    end

    // line stores; the upper store takes the old middle row in the cycle after it is read
    always_ff @(posedge clk)
    begin
        if (acc_go)
        begin
            mid_mem[col_s0] <= pix_s0;
            mid_q_reg       <= mid_mem[col_s0];
            top_q_reg       <= fwd ? mid_q_reg : up_mem[col_s0];
            s1_pix_reg      <= pix_s0;
            s1_emit_reg     <= emit_s0;
            s1_bd_reg       <= bd_s0;
            upw_addr_reg    <= col_s0;
        end
        if (upw_valid_reg)
            up_mem[upw_addr_reg] <= mid_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upw_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            upw_valid_reg <= acc_go;
            if (acc_go)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
        end
    end

    // window decision
    always_comb
    begin
        nb_any = ((win_t1_reg == bg_reg) && s1_bd_reg.up && s1_bd_reg.left)
              || ((win_t2_reg == bg_reg) && s1_bd_reg.up)
              || ((win_m1_reg == bg_reg) && s1_bd_reg.left)
              || ((mid_q_reg  == bg_reg) && s1_bd_reg.right)
              || ((win_b2_reg == bg_reg) && s1_bd_reg.down)
              || ((s1_pix_reg == bg_reg) && s1_bd_reg.down && s1_bd_reg.right);
        result = ((win_m2_reg == bg_reg) && !nb_any) ? fg_reg : win_m2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_t1_reg <= '0;
            win_t2_reg <= '0;
            win_m1_reg <= '0;
            win_m2_reg <= '0;
            win_b2_reg <= '0;
        end
        else if (s1_move)
        begin
            win_t1_reg <= win_t2_reg;
            win_t2_reg <= top_q_reg;
            win_m1_reg <= win_m2_reg;
            win_m2_reg <= mid_q_reg;
            win_b2_reg <= s1_pix_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move && s1_emit_reg)
            out_valid_reg <= 1'b1;
        else if (stream_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_emit_reg)
        begin
            pixel_out_reg <= result;
            row_end_reg   <= !s1_bd_reg.right || s1_bd_reg.last;
            frame_end_reg <= s1_bd_reg.last;
        end
    end

    assign stream_out.valid     = out_valid_reg;
    assign stream_out.pixel_out = pixel_out_reg;
    assign stream_out.row_end   = row_end_reg;
    assign stream_out.frame_end = frame_end_reg;

    a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> !stream_in.ready)
        else $error("input accepted while output position is rebuilt");

    a_out_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (CMPW'(out_col_reg) < CMPW'(eff_w)))
        else $error("output column beyond row width");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_go && !busy && emit_s0 && bd_s0.last)
            |=> (out_pos_reg == '0 && col_reg == '0 && row_reg == '0))
        else $error("positions not cleared after frame end");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_pix_reg)))
        else $error("stalled window stage lost its item");

endmodule
